// ===== hdl/cap_pkg.sv =====
// Shared types, constants and the coverage weight table for the pixel blend unit.
package cap_pkg;

    localparam int ChanW    = 8;
    localparam int DepthW   = 4;
    localparam int OffW     = 3;
    localparam int ApbAddrW = 5;
    localparam int ApbDataW = 32;
    localparam int LutDepth = 256;
    localparam int MaxDepth = 8;

    typedef enum logic [2:0] {
        REG_FG_ALPHA,
        REG_FG_RED,
        REG_FG_GREEN,
        REG_FG_BLUE,
        REG_COV_DEPTH
    } reg_idx_t;

    typedef struct packed {
        logic [ChanW-1:0]  alpha;
        logic [ChanW-1:0]  red;
        logic [ChanW-1:0]  green;
        logic [ChanW-1:0]  blue;
        logic [DepthW-1:0] depth;
    } cfg_t;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } rgb_t;

    typedef struct packed {
        logic             action;
        rgb_t             dst;
        logic [ChanW-1:0] cov_byte;
        logic [OffW-1:0]  bit_offset;
    } pix_req_t;

    typedef struct packed {
        logic [ChanW-1:0] weight;
        rgb_t             dst;
    } wpix_t;

    typedef logic [ChanW-1:0] weight_lut_t [LutDepth];

    // Entry {1, a} with a leading one at bit d holds floor((510*a + m) / (2*m)),
    // m = 2^d - 1. Built by search so no divide appears at all.
    function automatic weight_lut_t build_weight_lut();
        weight_lut_t lut;
        int d;
        int a;
        int m;
        int num;
        int den;
        int w;
        for (int idx = 0; idx < LutDepth; idx++) begin
            d = 0;
            for (int b = 1; b < MaxDepth; b++) begin
                if (idx >= (1 << b)) begin
                    d = b;
                end
            end
            w = 0;
            if (d > 0) begin
                a   = idx - (1 << d);
                m   = (1 << d) - 1;
                num = 510 * a + m;
                den = 2 * m;
                for (int q = 0; q < LutDepth; q++) begin
                    if (q * den <= num) begin
                        w = q;
                    end
                end
            end
            lut[idx] = w[ChanW-1:0];
        end
        return lut;
    endfunction

    localparam weight_lut_t WEIGHT_LUT = build_weight_lut();

endpackage

// ===== hdl/cap_ifs.sv =====
// Pixel request and result stream interfaces.
interface cap_in_if import cap_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             action;
    logic [ChanW-1:0] dst_red;
    logic [ChanW-1:0] dst_green;
    logic [ChanW-1:0] dst_blue;
    logic [ChanW-1:0] coverage_byte;
    logic [OffW-1:0]  bit_offset;

    modport source (
        output valid, action, dst_red, dst_green, dst_blue, coverage_byte, bit_offset,
        input  ready
    );
    modport sink (
        input  valid, action, dst_red, dst_green, dst_blue, coverage_byte, bit_offset,
        output ready
    );
endinterface

interface cap_out_if import cap_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ChanW-1:0] out_red;
    logic [ChanW-1:0] out_green;
    logic [ChanW-1:0] out_blue;

    modport source (
        output valid, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue,
        output ready
    );
endinterface

// ===== hdl/cap_cfg_regs.sv =====
// APB configuration registers: foreground color, fill alpha and coverage depth.
module cap_cfg_regs import cap_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel;
    logic     wr_en;

    assign pready = 1'b1;
    assign sel    = reg_idx_t'(paddr[ApbAddrW-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                REG_FG_ALPHA:  cfg_next.alpha = pwdata[ChanW-1:0];
                REG_FG_RED:    cfg_next.red   = pwdata[ChanW-1:0];
                REG_FG_GREEN:  cfg_next.green = pwdata[ChanW-1:0];
                REG_FG_BLUE:   cfg_next.blue  = pwdata[ChanW-1:0];
                REG_COV_DEPTH: cfg_next.depth = pwdata[DepthW-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_FG_ALPHA:  prdata = {{(ApbDataW-ChanW){1'b0}}, cfg_reg.alpha};
            REG_FG_RED:    prdata = {{(ApbDataW-ChanW){1'b0}}, cfg_reg.red};
            REG_FG_GREEN:  prdata = {{(ApbDataW-ChanW){1'b0}}, cfg_reg.green};
            REG_FG_BLUE:   prdata = {{(ApbDataW-ChanW){1'b0}}, cfg_reg.blue};
            REG_COV_DEPTH: prdata = {{(ApbDataW-DepthW){1'b0}}, cfg_reg.depth};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha <= 8'd255;
            cfg_reg.red   <= 8'd255;
            cfg_reg.green <= 8'd255;
            cfg_reg.blue  <= 8'd255;
            cfg_reg.depth <= 4'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/cap_weight_stage.sv =====
// Stages 1-2: coverage field extraction, then weight lookup and fill/bitmap select.
module cap_weight_stage import cap_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  pix_req_t in_req,
    output logic     out_valid,
    input  logic     out_ready,
    output wpix_t    out_pix
);

    typedef struct packed {
        logic             action;
        logic             full;
        logic [ChanW-1:0] idx;
        rgb_t             dst;
    } s1_t;

    logic             v1_reg;
    logic             v2_reg;
    s1_t              s1_reg;
    s1_t              s1_next;
    wpix_t            s2_reg;
    wpix_t            s2_next;
    logic             en1;
    logic             en2;
    logic [DepthW-1:0] depth;
    logic [DepthW-1:0] off_max;
    logic [DepthW-1:0] offset;
    logic [DepthW-1:0] shamt;
    logic [ChanW-1:0]  mask;
    logic [ChanW-1:0]  cov;
    logic [ChanW:0]    marked;
    logic [ChanW-1:0]  cov_w;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // Stage 1: clamp depth and offset, pull the coverage field out of the byte
    always_comb
    begin
        if (cfg.depth == '0)
            depth = DepthW'(1);
        else if (cfg.depth > DepthW'(MaxDepth))
            depth = DepthW'(MaxDepth);
        else
            depth = cfg.depth;
        off_max = DepthW'(MaxDepth) - depth;
        offset  = ({1'b0, in_req.bit_offset} > off_max) ? off_max : {1'b0, in_req.bit_offset};
        shamt   = DepthW'(MaxDepth) - depth - offset;
        mask    = ChanW'((9'd1 << depth) - 9'd1);
        cov     = (in_req.cov_byte >> shamt) & mask;
        // leading one marks the depth, giving a packed table index
        marked  = (9'd1 << depth) | {1'b0, cov};

        s1_next.action = in_req.action;
        s1_next.full   = (depth == DepthW'(MaxDepth));
        s1_next.idx    = s1_next.full ? cov : marked[ChanW-1:0];
        s1_next.dst    = in_req.dst;
    end

    // Stage 2: full-depth coverage is already 0..255
    always_comb
    begin
        cov_w          = s1_reg.full ? s1_reg.idx : WEIGHT_LUT[s1_reg.idx];
        s2_next.weight = s1_reg.action ? cov_w : cfg.alpha;
        s2_next.dst    = s1_reg.dst;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                v1_reg <= in_valid;
            if (en2)
                v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
            s1_reg <= s1_next;
        if (en2)
            s2_reg <= s2_next;
    end

    assign out_valid = v2_reg;
    assign out_pix   = s2_reg;

endmodule

// ===== hdl/cap_blend_stage.sv =====
// Stages 3-4: per-channel weighted products, then sum and scale down.
module cap_blend_stage import cap_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_valid,
    output logic  in_ready,
    input  wpix_t in_pix,
    output logic  out_valid,
    input  logic  out_ready,
    output rgb_t  out_rgb
);

    typedef struct packed {
        logic [2*ChanW-1:0] fg_r;
        logic [2*ChanW-1:0] fg_g;
        logic [2*ChanW-1:0] fg_b;
        logic [2*ChanW-1:0] dst_r;
        logic [2*ChanW-1:0] dst_g;
        logic [2*ChanW-1:0] dst_b;
    } prod_t;

    logic             v3_reg;
    logic             v4_reg;
    prod_t            p_reg;
    prod_t            p_next;
    rgb_t             o_reg;
    rgb_t             o_next;
    logic             en3;
    logic             en4;
    logic [ChanW-1:0] inv_w;
    logic [2*ChanW:0] sum_r;
    logic [2*ChanW:0] sum_g;
    logic [2*ChanW:0] sum_b;

    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign in_ready = en3;

    always_comb
    begin
        inv_w        = 8'd255 - in_pix.weight;
        p_next.fg_r  = 16'(cfg.red)   * 16'(in_pix.weight);
        p_next.fg_g  = 16'(cfg.green) * 16'(in_pix.weight);
        p_next.fg_b  = 16'(cfg.blue)  * 16'(in_pix.weight);
        p_next.dst_r = 16'(in_pix.dst.red)   * 16'(inv_w);
        p_next.dst_g = 16'(in_pix.dst.green) * 16'(inv_w);
        p_next.dst_b = 16'(in_pix.dst.blue)  * 16'(inv_w);
    end

    // sums stay below 2^16, so bits 15:8 are the >>8 result
    always_comb
    begin
        sum_r        = {1'b0, p_reg.fg_r} + {1'b0, p_reg.dst_r};
        sum_g        = {1'b0, p_reg.fg_g} + {1'b0, p_reg.dst_g};
        sum_b        = {1'b0, p_reg.fg_b} + {1'b0, p_reg.dst_b};
        o_next.red   = sum_r[2*ChanW-1:ChanW];
        o_next.green = sum_g[2*ChanW-1:ChanW];
        o_next.blue  = sum_b[2*ChanW-1:ChanW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en3)
                v3_reg <= in_valid;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
            p_reg <= p_next;
        if (en4)
            o_reg <= o_next;
    end

    assign out_valid = v4_reg;
    assign out_rgb   = o_reg;

endmodule

// ===== hdl/coverage_alpha_pixel_blend_unit.sv =====
// Top level of the coverage alpha pixel blend unit.
// An input passes the extract, lookup, multiply and sum registers before result valid.
// Throughput: one pixel per cycle; each of the four stages holds one pixel and stalls
// only when the stage after it is full and blocked.
// Reset (rst_n, async, active low) empties the pipeline and loads the registers with
// fg color 255/255/255, fg_alpha 255 and coverage_depth 1.
module coverage_alpha_pixel_blend_unit import cap_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    cap_in_if.sink              pix_in,
    cap_out_if.source           pix_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    cfg_t     cfg;
    pix_req_t req;
    wpix_t    wpix;
    logic     w_valid;
    logic     w_ready;
    rgb_t     res;

    assign req.action     = pix_in.action;
    assign req.dst.red    = pix_in.dst_red;
    assign req.dst.green  = pix_in.dst_green;
    assign req.dst.blue   = pix_in.dst_blue;
    assign req.cov_byte   = pix_in.coverage_byte;
    assign req.bit_offset = pix_in.bit_offset;

    cap_cfg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cap_weight_stage u_weight (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .in_req    (req),
        .out_valid (w_valid),
        .out_ready (w_ready),
        .out_pix   (wpix)
    );

    cap_blend_stage u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (w_valid),
        .in_ready  (w_ready),
        .in_pix    (wpix),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_rgb   (res)
    );

    assign pix_out.out_red   = res.red;
    assign pix_out.out_green = res.green;
    assign pix_out.out_blue  = res.blue;

endmodule

// ===== hdl/cap_checker.sv =====
// Port-level assertions for the blend unit, bound to the top level.
module cap_checker import cap_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [ChanW-1:0] out_red,
    input logic [ChanW-1:0] out_green,
    input logic [ChanW-1:0] out_blue
);

    // pipeline comes out of reset empty
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({out_red, out_green, out_blue}))
        else $error("stalled result changed or dropped");

    // with no result pending, no stage can be blocked
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output empty");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result missing four cycles after transaction");

endmodule

bind coverage_alpha_pixel_blend_unit cap_checker u_cap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pix_in.valid),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_red   (pix_out.out_red),
    .out_green (pix_out.out_green),
    .out_blue  (pix_out.out_blue)
);
